/* src/hex_record_flash_writer_defines.svh */
// Assertion macros shared by the hex record flash writer modules.
// Expects clk and arst_n in the scope of each use.
`ifndef HEX_RECORD_FLASH_WRITER_DEFINES_SVH
`define HEX_RECORD_FLASH_WRITER_DEFINES_SVH

// same-cycle implication
`define HRFW_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrfw: same-cycle check failed");

// next-cycle implication
`define HRFW_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hrfw: next-cycle check failed");

`endif

/* src/hrfw_pkg.sv */
// Types, constants and the hex digit decoder for the hex record flash writer.
// No dependencies.
package hrfw_pkg;

	localparam logic [9:0]  POS_MAX          = 10'd1023;
	localparam logic [7:0]  CHAR_ZERO        = 8'h30;
	localparam logic [7:0]  CHAR_NINE        = 8'h39;
	localparam logic [7:0]  CHAR_A           = 8'h41;
	localparam logic [7:0]  CHAR_F           = 8'h46;
	localparam logic [7:0]  LETTER_OFFSET    = 8'd55;
	localparam logic [15:0] BASE_HIGH_RESET  = 16'h0800;

	// character positions with a fixed meaning
	localparam logic [9:0]  POS_COUNT_HI     = 10'd1;
	localparam logic [9:0]  POS_COUNT_LO     = 10'd2;
	localparam logic [9:0]  POS_ADDR_FIRST   = 10'd3;
	localparam logic [9:0]  POS_ADDR_LAST    = 10'd6;
	localparam logic [9:0]  POS_KIND         = 10'd8;
	localparam logic [9:0]  POS_DATA         = 10'd9;

	// digit phase within a halfword group
	localparam logic [1:0]  PHASE_FIRST      = 2'd0;
	localparam logic [1:0]  PHASE_LAST       = 2'd3;

	typedef struct packed {
		logic [7:0] chr;
		logic       start;
	} item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [31:0] address;
		logic [15:0] data;
		logic        error;
		logic        last;
	} result_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t       h;
		logic [7:0] diff;
		h    = '0;
		diff = '0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			diff  = c - CHAR_ZERO;
			h.ok  = 1'b1;
			h.val = diff[3:0];
		end else if (c >= CHAR_A && c <= CHAR_F) begin
			diff  = c - LETTER_OFFSET;
			h.ok  = 1'b1;
			h.val = diff[3:0];
		end
		return h;
	endfunction

endpackage

/* src/hex_record_flash_writer.sv */
// After its fourth data digit passes the input register and is taken by the parser, a result is registered.
// Throughput: one character per cycle; the single record-state update per character
// sets it. A waiting write stalls the input once the input register holds a character.
// Reset: arst_n clears the stage valids and record state at once and loads the
// base high half with 0x0800.
// Top level of the hex record flash writer; depends on hrfw_pkg, hrfw_in_reg, hrfw_parser.

module hex_record_flash_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // flash_base_high
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] record_char
	input  logic        s_axis_tuser,  // [0] record_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [31:0] write_address, [47:32] write_data
	output logic        m_axis_tuser,  // [0] digit_error
	output logic        m_axis_tlast   // last_write
);

	hrfw_pkg::item_t   in_item;
	hrfw_pkg::item_t   item_s1;
	hrfw_pkg::result_t res;
	logic              valid_s1;
	logic              taken;

	assign in_item.chr   = s_axis_tdata;
	assign in_item.start = s_axis_tuser;

	hrfw_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.taken    (taken)
	);

	hrfw_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.taken     (taken),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {res.data, res.address};
	assign m_axis_tuser = res.error;
	assign m_axis_tlast = res.last;

endmodule

/* src/hrfw_in_reg.sv */
// Input register of the hex record flash writer: holds one accepted character.
// Depends on hrfw_pkg and hex_record_flash_writer_defines.svh.
`include "hex_record_flash_writer_defines.svh"

module hrfw_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hrfw_pkg::item_t in_item,
	output logic          valid_s1,
	output hrfw_pkg::item_t item_s1,
	input  logic          taken
);

	// a held item leaves when the parser takes it, so a new one may enter then
	assign in_ready = !valid_s1 || taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	`HRFW_ASSERT_NXT(a_hold_untaken, valid_s1 && !taken, valid_s1 && $stable(item_s1))
	`HRFW_ASSERT_IMP(a_take_needs_item, taken, valid_s1)

endmodule

/* src/hrfw_parser.sv */
// Record state, per-character decode and result register of the flash writer.
// Depends on hrfw_pkg and hex_record_flash_writer_defines.svh.
`include "hex_record_flash_writer_defines.svh"

module hrfw_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              valid_s1,
	input  hrfw_pkg::item_t   item_s1,
	output logic              taken,
	output logic              res_valid,
	input  logic              res_ready,
	output hrfw_pkg::result_t res
);

	logic [15:0] base_high_q;
	logic [9:0]  pos_q;
	logic [7:0]  bc_q;
	logic [15:0] la_q;
	logic [7:0]  kind_q;
	logic [11:0] nib_q;
	logic [6:0]  hw_q;
	logic        err_q;

	// values after an optional record start
	logic [9:0]  pos;
	logic [7:0]  bc;
	logic [15:0] la;
	logic [7:0]  kind;
	logic [11:0] nib;
	logic [6:0]  hw;
	logic        err;

	logic [9:0]  pos_n;
	logic [7:0]  bc_n;
	logic [15:0] la_n;
	logic [7:0]  kind_n;
	logic [11:0] nib_n;
	logic [6:0]  hw_n;
	logic        err_n;

	hrfw_pkg::hex_t    hex;
	hrfw_pkg::result_t res_n;
	logic              emit;
	logic [1:0]        phase;

	assign taken = valid_s1 && (!res_valid || res_ready);

	always_comb begin
		pos  = item_s1.start ? '0 : pos_q;
		bc   = item_s1.start ? '0 : bc_q;
		la   = item_s1.start ? '0 : la_q;
		kind = item_s1.start ? '0 : kind_q;
		nib  = item_s1.start ? '0 : nib_q;
		hw   = item_s1.start ? '0 : hw_q;
		err  = item_s1.start ? 1'b0 : err_q;

		hex   = hrfw_pkg::hex_decode(item_s1.chr);
		// data starts at position nine, which is one past a multiple of four
		phase = pos[1:0] - 2'd1;

		bc_n   = bc;
		la_n   = la;
		kind_n = kind;
		nib_n  = nib;
		hw_n   = hw;
		err_n  = err;
		emit   = 1'b0;

		if (pos >= hrfw_pkg::POS_COUNT_HI && pos <= hrfw_pkg::POS_ADDR_LAST) begin
			err_n = err | !hex.ok;
			if (pos == hrfw_pkg::POS_COUNT_HI) begin
				bc_n = {4'b0, hex.val};
			end else if (pos == hrfw_pkg::POS_COUNT_LO) begin
				bc_n = {bc[3:0], hex.val};
			end else if (pos == hrfw_pkg::POS_ADDR_FIRST) begin
				la_n = {12'b0, hex.val};
			end else begin
				la_n = {la[11:0], hex.val};
			end
		end else if (pos == hrfw_pkg::POS_KIND) begin
			kind_n = item_s1.chr;
		end else if (pos >= hrfw_pkg::POS_DATA && kind == hrfw_pkg::CHAR_ZERO
				&& hw < bc[7:1]) begin
			err_n = err | !hex.ok;
			if (phase == hrfw_pkg::PHASE_FIRST) begin
				nib_n = {8'b0, hex.val};
			end else if (phase != hrfw_pkg::PHASE_LAST) begin
				nib_n = {nib[7:0], hex.val};
			end else begin
				emit = 1'b1;
				hw_n = hw + 7'd1;
			end
		end

		pos_n = (pos == hrfw_pkg::POS_MAX) ? pos : pos + 10'd1;

		// digits arrive d1 d2 d3 d4; the halfword is d3 d4 d1 d2
		res_n.address = {base_high_q, la} + {24'b0, hw, 1'b0};
		res_n.data    = {nib[3:0], hex.val, nib[11:8], nib[7:4]};
		res_n.error   = err_n;
		res_n.last    = (hw_n == bc[7:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_high_q <= hrfw_pkg::BASE_HIGH_RESET;
		end else if (cfg_we) begin
			base_high_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			bc_q   <= '0;
			la_q   <= '0;
			kind_q <= '0;
			nib_q  <= '0;
			hw_q   <= '0;
			err_q  <= 1'b0;
		end else if (taken) begin
			pos_q  <= pos_n;
			bc_q   <= bc_n;
			la_q   <= la_n;
			kind_q <= kind_n;
			nib_q  <= nib_n;
			hw_q   <= hw_n;
			err_q  <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (taken) begin
			res_valid <= emit;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (taken && emit) begin
			res <= res_n;
		end
	end

	`HRFW_ASSERT_NXT(a_emit_shows, taken && emit, res_valid)
	`HRFW_ASSERT_IMP(a_index_bound, 1'b1, hw_q <= bc_q[7:1])
	`HRFW_ASSERT_NXT(a_last_ends, taken && emit && res_n.last, hw_q == bc_q[7:1])

endmodule
